>>> hw/rtl/sfc_pkg.sv
`default_nettype none

package sfc_pkg;

  localparam int unsigned StoreDepth = 12;
  localparam int unsigned NameMaxLen = 8;
  localparam int unsigned ExtMaxLen  = 3;

  localparam logic [7:0] DOT         = 8'h2E;
  localparam logic [7:0] DEL_MARK    = 8'hE5;
  localparam logic [7:0] DEL_SUBST   = 8'h05;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] UNDERSCORE  = 8'h5F;
  localparam logic [7:0] SPACE       = 8'h20;

  typedef logic [NameMaxLen-1:0][7:0] name_bytes_t;
  typedef logic [ExtMaxLen-1:0][7:0]  ext_bytes_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic        valid_res;
    logic [63:0] name_chars;
    logic [23:0] ext_chars;
  } out_word_t;

  // Snapshot of one complete name, handed from collector to converter.
  typedef struct packed {
    name_bytes_t name_b;
    ext_bytes_t  ext_b;
    logic [3:0]  char_count;
    logic [3:0]  last_dot_pos;
    logic [1:0]  dot_seen_count;
    logic [2:0]  ext_count;
    logic        overflowed;
  } frame_t;

  // Uppercase letters, keep digits, everything else becomes an underscore.
  function automatic logic [7:0] map_byte(input logic [7:0] c);
    logic [7:0] r;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - CASE_OFFSET;
    end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39)) begin
      r = c;
    end else begin
      r = UNDERSCORE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sfc_collect.sv
`default_nettype none

module sfc_collect (
  input  wire                logic      clk_i,
  input  wire                logic      rst_ni,
  input  wire                logic      in_valid_i,
  input  wire sfc_pkg::in_word_t        in_word_i,
  output logic                          in_stall_o,
  input  wire                logic      take_i,
  output logic                          frame_valid_o,
  output sfc_pkg::frame_t               frame_o
);

  sfc_pkg::name_bytes_t name_q, name_n;
  sfc_pkg::ext_bytes_t  ext_q, ext_n;
  logic [3:0] cnt_q, cnt_n;
  logic [3:0] dotpos_q, dotpos_n;
  logic [1:0] dotcnt_q, dotcnt_n;
  logic [2:0] extcnt_q, extcnt_n;
  logic       ovf_q, ovf_n;
  logic       frame_valid_q, frame_valid_d;
  sfc_pkg::frame_t frame_q;
  logic       accept;
  logic       stored;
  logic       is_dot;

  // Hold the input while a finished frame cannot move on.
  assign in_stall_o = frame_valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    stored   = cnt_q < 4'(sfc_pkg::StoreDepth);
    is_dot   = in_word_i.char_in == sfc_pkg::DOT;
    name_n   = name_q;
    ext_n    = ext_q;
    cnt_n    = cnt_q;
    dotpos_n = dotpos_q;
    dotcnt_n = dotcnt_q;
    extcnt_n = extcnt_q;
    ovf_n    = ovf_q;
    if (stored) begin
      cnt_n = cnt_q + 4'd1;
      if (cnt_q < 4'(sfc_pkg::NameMaxLen)) begin
        name_n[cnt_q[2:0]] = in_word_i.char_in;
      end
      if (is_dot) begin
        dotpos_n = cnt_q;
        extcnt_n = 3'd0;
        if (dotcnt_q != 2'd3) begin
          dotcnt_n = dotcnt_q + 2'd1;
        end
      end else if (extcnt_q <= 3'(sfc_pkg::ExtMaxLen)) begin
        // Count bytes after the last dot; saturate one above the limit.
        if (extcnt_q < 3'(sfc_pkg::ExtMaxLen)) begin
          ext_n[extcnt_q[1:0]] = in_word_i.char_in;
        end
        extcnt_n = extcnt_q + 3'd1;
      end
    end else begin
      ovf_n = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      name_q <= name_n;
      ext_q  <= ext_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      dotpos_q <= '0;
      dotcnt_q <= '0;
      extcnt_q <= '0;
      ovf_q    <= 1'b0;
    end else if (accept) begin
      if (in_word_i.last) begin
        cnt_q    <= '0;
        dotpos_q <= '0;
        dotcnt_q <= '0;
        extcnt_q <= '0;
        ovf_q    <= 1'b0;
      end else begin
        cnt_q    <= cnt_n;
        dotpos_q <= dotpos_n;
        dotcnt_q <= dotcnt_n;
        extcnt_q <= extcnt_n;
        ovf_q    <= ovf_n;
      end
    end
  end

  always_comb begin
    frame_valid_d = frame_valid_q;
    if (accept && in_word_i.last) begin
      frame_valid_d = 1'b1;
    end else if (take_i) begin
      frame_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= 1'b0;
    end else begin
      frame_valid_q <= frame_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_word_i.last) begin
      frame_q.name_b         <= name_n;
      frame_q.ext_b          <= ext_n;
      frame_q.char_count     <= cnt_n;
      frame_q.last_dot_pos   <= dotpos_n;
      frame_q.dot_seen_count <= dotcnt_n;
      frame_q.ext_count      <= extcnt_n;
      frame_q.overflowed     <= ovf_n;
    end
  end

  assign frame_valid_o = frame_valid_q;
  assign frame_o       = frame_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'(sfc_pkg::StoreDepth))
    else $error("byte count beyond store depth");

  a_ext_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    extcnt_q <= 3'(sfc_pkg::ExtMaxLen + 1))
    else $error("extension count beyond saturation");

  a_dotpos_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dotcnt_q == 2'd0 |-> dotpos_q == 4'd0)
    else $error("dot position set without any dot");

  a_frame_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_q && !take_i |=> frame_valid_q)
    else $error("frame dropped before it was taken");

endmodule

`default_nettype wire

>>> hw/rtl/sfc_convert.sv
`default_nettype none

module sfc_convert (
  input  wire                logic      clk_i,
  input  wire                logic      rst_ni,
  input  wire                logic      frame_valid_i,
  input  wire sfc_pkg::frame_t          frame_i,
  output logic                          take_o,
  output logic                          out_valid_o,
  input  wire                logic      out_stall_i,
  output sfc_pkg::out_word_t            out_word_o
);

  logic [3:0] name_len;
  logic [2:0] ext_len;
  logic       ok;
  logic [7:0] b;
  sfc_pkg::out_word_t res;
  sfc_pkg::out_word_t out_q;
  logic       out_valid_q;

  assign take_o = frame_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (frame_i.dot_seen_count == 2'd0) begin
      name_len = frame_i.char_count;
      ext_len  = 3'd0;
    end else begin
      name_len = frame_i.last_dot_pos;
      ext_len  = frame_i.ext_count;
    end
    ok = !frame_i.overflowed && frame_i.name_b[0] != sfc_pkg::DOT &&
         name_len <= 4'(sfc_pkg::NameMaxLen) && ext_len <= 3'(sfc_pkg::ExtMaxLen) &&
         frame_i.dot_seen_count < 2'd2;
    res = '0;
    res.valid_res = ok;
    if (ok) begin
      for (int i = 0; i < sfc_pkg::NameMaxLen; i++) begin
        b = sfc_pkg::SPACE;
        if (4'(i) < name_len) begin
          b = frame_i.name_b[3'(i)];
          if (i == 0 && b == sfc_pkg::DEL_MARK) begin
            b = sfc_pkg::DEL_SUBST;
          end
          b = sfc_pkg::map_byte(b);
        end
        res.name_chars[63-8*i -: 8] = b;
      end
      for (int i = 0; i < sfc_pkg::ExtMaxLen; i++) begin
        b = sfc_pkg::SPACE;
        if (3'(i) < ext_len) begin
          b = sfc_pkg::map_byte(frame_i.ext_b[2'(i)]);
        end
        res.ext_chars[23-8*i -: 8] = b;
      end
    end else begin
      b = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.valid_res |-> out_q.name_chars == '0 && out_q.ext_chars == '0)
    else $error("rejected name carries nonzero bytes");

  a_name_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.valid_res |-> out_q.name_chars[63:56] != sfc_pkg::SPACE)
    else $error("accepted name has empty name part");

  a_take_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> out_valid_q)
    else $error("taken frame did not reach the result register");

endmodule

`default_nettype wire

>>> hw/rtl/short_filename_converter_unit.sv
// Path: a final byte's result goes via the snapshot register, then the result
//   register. Throughput: one byte word per cycle unless the output stalls;
//   results back to back, no bubbles.
// Reset: byte counts, dot tracking and all valid flags clear; the stored bytes
//   are left as they are and are only read after being written.
`default_nettype none

module short_filename_converter_unit (
  input  wire                logic      clk_i,
  input  wire                logic      rst_ni,
  input  wire                logic      in_valid_i,
  output logic                          in_stall_o,
  input  wire sfc_pkg::in_word_t        in_word_i,
  output logic                          out_valid_o,
  input  wire                logic      out_stall_i,
  output sfc_pkg::out_word_t            out_word_o
);

  // Frame handoff between the byte collector and the 8.3 converter.
  logic            frame_valid;
  sfc_pkg::frame_t frame;
  logic            take;

  // Collect bytes of the current name; on the final byte snapshot the
  // name part, extension bytes, counts and dot tracking into one frame.
  sfc_collect u_collect (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_word_i     (in_word_i),
    .in_stall_o    (in_stall_o),
    .take_i        (take),
    .frame_valid_o (frame_valid),
    .frame_o       (frame)
  );

  // Check the frame, map and pad the bytes, and hold the result word until
  // the downstream side takes it. A new frame advances whenever the result
  // register is empty or draining, so the input only stalls when both the
  // frame and the result are stuck.
  sfc_convert u_convert (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_valid),
    .frame_i       (frame),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_word_o    (out_word_o)
  );

endmodule

`default_nettype wire
